// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset
`define WS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset
`define WS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wsteer_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the steering block
`timescale 1ns / 1ps

package wsteer_pkg;

    // Default sizing
    localparam int WS_MAX_WAYPOINTS = 256;
    localparam int WS_CORDIC_STEPS  = 16;

    // Item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PLACE = 2'd1;
    localparam logic [1:0] MODE_MOVE  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROXIMITY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT     = 2'd2;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = 50;

    // CORDIC datapath widths
    localparam int CRD_XY_W    = 36;
    localparam int CRD_Z_W     = 34;
    localparam int ATAN_IDX_W  = 5;
    localparam logic signed [CRD_XY_W-1:0] GAIN_INV = 36'sd652032874;

    // Sequencer to CORDIC control and status
    typedef struct packed {
        logic start;
        logic vec;
    } crd_ctl_t;

    typedef struct packed {
        logic busy;
    } crd_sts_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [31:0] atan_ent(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/wsteer_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module wsteer_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/wsteer_mul.sv
// Shared signed multiplier with registered product and hold enable
`timescale 1ns / 1ps

module wsteer_mul import wsteer_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] p_next;

    // full-precision product
    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/wsteer_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode
`timescale 1ns / 1ps

module wsteer_cordic import wsteer_pkg::*; #(
    parameter int STEPS = WS_CORDIC_STEPS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  crd_ctl_t                   ctl,
    input  logic signed [CRD_XY_W-1:0] x_in,
    input  logic signed [CRD_XY_W-1:0] y_in,
    input  logic signed [CRD_Z_W-1:0]  z_in,
    output crd_sts_t                   sts,
    output logic signed [CRD_XY_W-1:0] x_out,
    output logic signed [CRD_XY_W-1:0] y_out,
    output logic signed [CRD_Z_W-1:0]  z_out
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                       run_reg;
    logic                       vec_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [CRD_XY_W-1:0] x_reg;
    logic signed [CRD_XY_W-1:0] y_reg;
    logic signed [CRD_Z_W-1:0]  z_reg;
    logic signed [CRD_XY_W-1:0] x_next;
    logic signed [CRD_XY_W-1:0] y_next;
    logic signed [CRD_Z_W-1:0]  z_next;
    logic signed [CRD_XY_W-1:0] xs;
    logic signed [CRD_XY_W-1:0] ys;
    logic signed [CRD_Z_W-1:0]  tab;
    logic                       ccw;

    // one micro-rotation: shift, add/sub and angle update
    always_comb
    begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        tab = CRD_Z_W'(atan_ent(ATAN_IDX_W'(cnt_reg)));
        ccw = vec_reg ? (y_reg <= 0) : (z_reg >= 0);
        if (ccw)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - tab;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + tab;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            vec_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
            vec_reg <= ctl.vec;
        end
        else if (run_reg)
        begin
            if (cnt_reg == LAST)
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // working vector
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign sts.busy = run_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

// File: rtl/waypoint_heading_steering_step_core.sv
// Top level of the waypoint steering block: sequencer, state and result register
`timescale 1ns / 1ps

// Waypoint-following vehicle step engine.
// Input channel (in_valid / in_stall) carries one word per item: mode load
// writes waypoint_index <- (waypoint_x, waypoint_y), place puts the vehicle on
// waypoint 0 with heading 0, move advances one time_step. Output channel
// (out_valid / out_stall) returns one word per item: position, motion,
// heading and target after the item.
// Configuration (cfg_write, cfg_index, cfg_data) sets speed, proximity and
// waypoint count; write only while no item is in flight.
// A move's run time is set by the one CORDIC unit, used first for the bearing
// (skipped when the vehicle sits on the target) and then for cos/sin, and by
// the one registered multiplier shared by every product.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is written into the output register, which then frees the sequencer.
// If out_stall holds the previous word, the new result waits in the
// sequencer. Reset clears the position, heading, target and the output valid,
// and loads speed 2560, proximity 1280 and count 1; the waypoint table holds
// nothing until loaded.

module waypoint_heading_steering_step_core import wsteer_pkg::*; #(
    parameter int MAX_WAYPOINTS = WS_MAX_WAYPOINTS,
    parameter int CORDIC_STEPS  = WS_CORDIC_STEPS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    input  logic [7:0]             waypoint_index,
    input  logic signed [31:0]     waypoint_x,
    input  logic signed [31:0]     waypoint_y,
    input  logic [15:0]            time_step,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     position_x,
    output logic signed [31:0]     position_y,
    output logic signed [31:0]     motion_x,
    output logic signed [31:0]     motion_y,
    output logic [15:0]            heading_out,
    output logic [7:0]             target_out
);

    localparam int ADDR_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CAP    = (MAX_WAYPOINTS < 256) ? MAX_WAYPOINTS : 256;
    localparam logic [8:0] CNT_CAP = 9'(CAP);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PLACE = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_M1    = 5'd3;
    localparam logic [4:0] S_M2    = 5'd4;
    localparam logic [4:0] S_M3    = 5'd5;
    localparam logic [4:0] S_M4    = 5'd6;
    localparam logic [4:0] S_VEC   = 5'd7;
    localparam logic [4:0] S_E1    = 5'd8;
    localparam logic [4:0] S_E2    = 5'd9;
    localparam logic [4:0] S_ROT0  = 5'd10;
    localparam logic [4:0] S_ROT   = 5'd11;
    localparam logic [4:0] S_C1    = 5'd12;
    localparam logic [4:0] S_C2    = 5'd13;
    localparam logic [4:0] S_C3    = 5'd14;
    localparam logic [4:0] S_C4    = 5'd15;
    localparam logic [4:0] S_C5    = 5'd16;
    localparam logic [4:0] S_C6    = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    // fixed-point constants
    localparam logic signed [32:0]         NEAR_HI = 33'sd65536;
    localparam logic signed [32:0]         NEAR_LO = -33'sd65536;
    localparam logic signed [CRD_Z_W-1:0]  Z_Q30   = CRD_Z_W'(64'sd1073741824);
    localparam logic signed [CRD_Z_W-1:0]  Z_Q31   = CRD_Z_W'(64'sd2147483648);
    localparam logic signed [CRD_XY_W-1:0] XY_ONE  = CRD_XY_W'(64'sd1073741824);
    localparam logic signed [63:0]         RND46   = 64'sd35184372088832;
    localparam logic signed [32:0]         SAT_HI  = 33'sd2147483647;
    localparam logic signed [32:0]         SAT_LO  = -33'sd2147483648;

    // control state
    logic [4:0]  state_reg, state_next;
    logic [15:0] speed_reg;
    logic [15:0] prox_reg;
    logic [8:0]  count_reg;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic [15:0] heading_reg, heading_next;
    logic [7:0]  target_reg, target_next;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [7:0]         t_reg, t_next;
    logic [15:0]        ts_reg, ts_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [15:0]        dir_reg, dir_next;
    logic               flip_reg, flip_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] s_reg, s_next;
    logic [31:0]        k_reg, k_next;
    logic signed [17:0] nx_reg, nx_next;
    logic signed [31:0] mot_x_reg, mot_x_next;
    logic signed [31:0] mot_y_reg, mot_y_next;

    // result register
    logic signed [31:0] opx_reg, opx_next;
    logic signed [31:0] opy_reg, opy_next;
    logic signed [31:0] omx_reg, omx_next;
    logic signed [31:0] omy_reg, omy_next;
    logic [15:0]        oh_reg, oh_next;
    logic [7:0]         ot_reg, ot_next;

    // datapath wiring
    logic                       in_acc;
    logic [8:0]                 cnt_eff;
    logic [7:0]                 t_sel;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [63:0]                ram_rdata;
    logic signed [31:0]         tab_x;
    logic signed [31:0]         tab_y;
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    crd_ctl_t                   crd_ctl;
    crd_sts_t                   crd_sts;
    logic signed [CRD_XY_W-1:0] crd_x_in;
    logic signed [CRD_XY_W-1:0] crd_y_in;
    logic signed [CRD_Z_W-1:0]  crd_z_in;
    logic signed [CRD_XY_W-1:0] crd_x;
    logic signed [CRD_XY_W-1:0] crd_y;
    logic signed [CRD_Z_W-1:0]  crd_z;

    // scratch
    logic signed [17:0]         dx18;
    logic signed [17:0]         dy18;
    logic                       near;
    logic [15:0]                err;
    logic [31:0]                ang_r;
    logic signed [39:0]         p40;
    logic signed [39:0]         dq;
    logic signed [CRD_Z_W-1:0]  zh;
    logic signed [CRD_XY_W-1:0] cx;
    logic signed [CRD_XY_W-1:0] cy;
    logic signed [63:0]         rnd;
    logic signed [17:0]         ny;
    logic signed [32:0]         sum_x;
    logic signed [32:0]         sum_y;
    logic signed [31:0]         npx;
    logic signed [31:0]         npy;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // effective waypoint count and current target
    always_comb
    begin
        if (count_reg == 9'd0)
        begin
            cnt_eff = 9'd1;
        end
        else if (count_reg > CNT_CAP)
        begin
            cnt_eff = CNT_CAP;
        end
        else
        begin
            cnt_eff = count_reg;
        end
        t_sel = ({1'b0, target_reg} >= cnt_eff) ? 8'd0 : target_reg;
    end

    // waypoint table
    assign ram_we    = in_acc && (mode == MODE_LOAD)
                       && (32'(waypoint_index) < 32'(MAX_WAYPOINTS));
    assign ram_waddr = ADDR_W'(waypoint_index);
    assign ram_raddr = (mode == MODE_PLACE) ? '0 : ADDR_W'(t_sel);
    assign tab_x     = ram_rdata[63:32];
    assign tab_y     = ram_rdata[31:0];

    wsteer_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({waypoint_x, waypoint_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wsteer_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    wsteer_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crd_ctl),
        .x_in  (crd_x_in),
        .y_in  (crd_y_in),
        .z_in  (crd_z_in),
        .sts   (crd_sts),
        .x_out (crd_x),
        .y_out (crd_y),
        .z_out (crd_z)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg && out_stall;
        t_next         = t_reg;
        ts_next        = ts_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        dir_next       = dir_reg;
        flip_next      = flip_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        nx_next        = nx_reg;
        mot_x_next     = mot_x_reg;
        mot_y_next     = mot_y_reg;
        opx_next       = opx_reg;
        opy_next       = opy_reg;
        omx_next       = omx_reg;
        omy_next       = omy_reg;
        oh_next        = oh_reg;
        ot_next        = ot_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        crd_ctl        = '0;
        crd_x_in       = '0;
        crd_y_in       = '0;
        crd_z_in       = '0;

        dx18  = dx_reg[17:0];
        dy18  = dy_reg[17:0];
        near  = (dx_reg > NEAR_LO) && (dx_reg < NEAR_HI)
                && (dy_reg > NEAR_LO) && (dy_reg < NEAR_HI);
        err   = dir_reg - heading_reg;
        ang_r = crd_z[31:0] + 32'h0000_8000;
        p40   = 40'(mul_p);
        dq    = (p40 + (p40 <<< 2) + 40'sd32768) >>> 16;
        zh    = CRD_Z_W'(signed'({heading_reg, 16'h0000}));
        cx    = flip_reg ? -crd_x : crd_x;
        cy    = flip_reg ? -crd_y : crd_y;
        rnd   = acc_reg + RND46;
        ny    = 18'(rnd >>> 46);
        sum_x = 33'(pos_x_reg) + 33'(nx_reg);
        sum_y = 33'(pos_y_reg) + 33'(ny);
        if (sum_x > SAT_HI)
        begin
            npx = 32'sh7FFF_FFFF;
        end
        else if (sum_x < SAT_LO)
        begin
            npx = 32'sh8000_0000;
        end
        else
        begin
            npx = sum_x[31:0];
        end
        if (sum_y > SAT_HI)
        begin
            npy = 32'sh7FFF_FFFF;
        end
        else if (sum_y < SAT_LO)
        begin
            npy = 32'sh8000_0000;
        end
        else
        begin
            npy = sum_y[31:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ts_next = time_step;
                    case (mode)
                        MODE_PLACE:
                        begin
                            state_next = S_PLACE;
                        end
                        MODE_MOVE:
                        begin
                            t_next     = t_sel;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            // load, or the unused code: no motion
                            mot_x_next = '0;
                            mot_y_next = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_PLACE:
            begin
                pos_x_next   = tab_x;
                pos_y_next   = tab_y;
                heading_next = '0;
                target_next  = '0;
                mot_x_next   = signed'({16'h0000, speed_reg});
                mot_y_next   = '0;
                state_next   = S_OUT;
            end
            S_RD:
            begin
                dx_next    = 33'(tab_x) - 33'(pos_x_reg);
                dy_next    = 33'(tab_y) - 33'(pos_y_reg);
                state_next = S_M1;
            end
            S_M1:
            begin
                // dx squared
                mul_en     = 1'b1;
                mul_a      = dx18;
                mul_b      = MUL_B_W'(dx18);
                state_next = S_M2;
            end
            S_M2:
            begin
                // dy squared
                acc_next   = 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = dy18;
                mul_b      = MUL_B_W'(dy18);
                state_next = S_M3;
            end
            S_M3:
            begin
                // proximity squared
                acc_next   = acc_reg + 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(prox_reg);
                mul_b      = MUL_B_W'(prox_reg);
                state_next = S_M4;
            end
            S_M4:
            begin
                // waypoint reached: step the target, but steer at the old one
                if (near && (acc_reg < 64'(mul_p)))
                begin
                    if (({1'b0, t_reg} + 9'd1) == cnt_eff)
                    begin
                        target_next = '0;
                    end
                    else
                    begin
                        target_next = t_reg + 8'd1;
                    end
                end
                else
                begin
                    target_next = t_reg;
                end
                if ((dx_reg == '0) && (dy_reg == '0))
                begin
                    dir_next   = '0;
                    state_next = S_E1;
                end
                else
                begin
                    crd_ctl.start = 1'b1;
                    crd_ctl.vec   = 1'b1;
                    if (dx_reg < 0)
                    begin
                        crd_x_in = -CRD_XY_W'(dx_reg);
                        crd_y_in = -CRD_XY_W'(dy_reg);
                        crd_z_in = Z_Q31;
                    end
                    else
                    begin
                        crd_x_in = CRD_XY_W'(dx_reg);
                        crd_y_in = CRD_XY_W'(dy_reg);
                        crd_z_in = '0;
                    end
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                // bearing, rounded half up to 16 bits
                if (!crd_sts.busy)
                begin
                    dir_next   = ang_r[31:16];
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(signed'(err));
                mul_b      = MUL_B_W'(ts_reg);
                state_next = S_E2;
            end
            S_E2:
            begin
                // heading += round(err * 5 * dt)
                heading_next = heading_reg + dq[15:0];
                state_next   = S_ROT0;
            end
            S_ROT0:
            begin
                // fold the angle into the right half plane
                crd_ctl.start = 1'b1;
                crd_ctl.vec   = 1'b0;
                crd_x_in      = GAIN_INV;
                crd_y_in      = '0;
                if (zh > Z_Q30)
                begin
                    crd_z_in  = zh - Z_Q31;
                    flip_next = 1'b1;
                end
                else if (zh < -Z_Q30)
                begin
                    crd_z_in  = zh + Z_Q31;
                    flip_next = 1'b1;
                end
                else
                begin
                    crd_z_in  = zh;
                    flip_next = 1'b0;
                end
                // speed * dt while the CORDIC runs
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(speed_reg);
                mul_b      = MUL_B_W'(ts_reg);
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!crd_sts.busy)
                begin
                    if (cx > XY_ONE)
                    begin
                        c_next = 32'(XY_ONE);
                    end
                    else if (cx < -XY_ONE)
                    begin
                        c_next = 32'(-XY_ONE);
                    end
                    else
                    begin
                        c_next = 32'(cx);
                    end
                    if (cy > XY_ONE)
                    begin
                        s_next = 32'(XY_ONE);
                    end
                    else if (cy < -XY_ONE)
                    begin
                        s_next = 32'(-XY_ONE);
                    end
                    else
                    begin
                        s_next = 32'(cy);
                    end
                    k_next     = mul_p[31:0];
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(k_reg[15:0]);
                mul_b      = c_reg;
                state_next = S_C2;
            end
            S_C2:
            begin
                acc_next   = 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(k_reg[31:16]);
                mul_b      = c_reg;
                state_next = S_C3;
            end
            S_C3:
            begin
                acc_next   = acc_reg + (64'(mul_p) <<< 16);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(k_reg[15:0]);
                mul_b      = s_reg;
                state_next = S_C4;
            end
            S_C4:
            begin
                nx_next    = 18'(rnd >>> 46);
                acc_next   = 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(k_reg[31:16]);
                mul_b      = s_reg;
                state_next = S_C5;
            end
            S_C5:
            begin
                acc_next   = acc_reg + (64'(mul_p) <<< 16);
                state_next = S_C6;
            end
            S_C6:
            begin
                // saturated position; motion is what was really applied
                pos_x_next = npx;
                pos_y_next = npy;
                mot_x_next = 32'(33'(npx) - 33'(pos_x_reg));
                mot_y_next = 32'(33'(npy) - 33'(pos_y_reg));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    opx_next       = pos_x_reg;
                    opy_next       = pos_y_reg;
                    omx_next       = mot_x_reg;
                    omy_next       = mot_y_reg;
                    oh_next        = heading_reg;
                    ot_next        = target_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= 16'd2560;
            prox_reg      <= 16'd1280;
            count_reg     <= 9'd1;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SPEED:     speed_reg <= cfg_data;
                    REG_PROXIMITY: prox_reg  <= cfg_data;
                    REG_COUNT:     count_reg <= cfg_data[8:0];
                    default:       ;
                endcase
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        ts_reg    <= ts_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        acc_reg   <= acc_next;
        dir_reg   <= dir_next;
        flip_reg  <= flip_next;
        c_reg     <= c_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        nx_reg    <= nx_next;
        mot_x_reg <= mot_x_next;
        mot_y_reg <= mot_y_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        omx_reg   <= omx_next;
        omy_reg   <= omy_next;
        oh_reg    <= oh_next;
        ot_reg    <= ot_next;
    end

    assign out_valid   = out_valid_reg;
    assign position_x  = opx_reg;
    assign position_y  = opy_reg;
    assign motion_x    = omx_reg;
    assign motion_y    = omy_reg;
    assign heading_out = oh_reg;
    assign target_out  = ot_reg;

endmodule

// File: rtl/wsteer_chk.sv
// Port-level checker for the steering block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsteer_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] position_x,
    input logic signed [31:0] position_y,
    input logic [15:0]        heading_out
);

    // a stalled result word stays offered
    `WS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")

    // and keeps its payload
    `WS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(position_x) && $stable(position_y) && $stable(heading_out), "stalled word changed")

    // an accepted word keeps the block busy on the next cycle
    `WS_ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall, "second word taken at once")

    // a new result only comes out of a busy sequencer
    `WS_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind waypoint_heading_steering_step_core wsteer_chk u_chk (.*);
